// ===== design/qpht_pkg.sv =====
`timescale 1ns / 1ps

package qpht_pkg;

   // Field widths of the request and response.
   localparam int KEY_W    = 31;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   // Default number of slots in the table.
   localparam int DEF_TABLE_SIZE = 16;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

   // One table entry: occupied mark and stored key.
   typedef struct packed {
      logic             occupied;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

// ===== design/qpht_home.sv =====
`timescale 1ns / 1ps

module qpht_home #(
   parameter int TableSize = qpht_pkg::DEF_TABLE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [qpht_pkg::KEY_W-1:0]   key,
   output logic                         done,
   output logic [$clog2(TableSize)-1:0] home
);

   localparam int SlotW  = $clog2(TableSize);
   localparam int RemW   = SlotW + 1;
   localparam int FoldW  = 20;
   localparam bit IsPow2 = (TableSize & (TableSize - 1)) == 0;

   // Weights of the upper key bytes modulo the table size.
   localparam logic [FoldW-1:0] Weight1 = FoldW'((1 << 8) % TableSize);
   localparam logic [FoldW-1:0] Weight2 = FoldW'((1 << 16) % TableSize);
   localparam logic [FoldW-1:0] Weight3 = FoldW'((1 << 24) % TableSize);
   localparam logic [FoldW-1:0] Divisor = FoldW'(TableSize);
   localparam logic [FoldW-1:0] Recip   = FoldW'((1 << FoldW) / TableSize);
   localparam logic [RemW-1:0]  SizeR   = RemW'(TableSize);

   logic               fold_vld_ff, fold_vld_in;
   logic               quot_vld_ff, quot_vld_in;
   logic               done_ff, done_in;
   logic [FoldW-1:0]   fold_ff, fold_in;
   logic [FoldW-1:0]   quot_ff, quot_in;
   logic [SlotW-1:0]   rem_ff, rem_in;
   logic [2*FoldW-1:0] prod;
   logic [FoldW-1:0]   back;
   logic [FoldW-1:0]   diff;
   logic [RemW-1:0]    near;

   // The folded key stays below 2^20. The reciprocal estimate of the quotient
   // is low by at most one, so one compare-subtract finishes the remainder.
   always_comb begin
      prod = {{FoldW{1'b0}}, fold_ff} * {{FoldW{1'b0}}, Recip};
      back = quot_ff * Divisor;
      diff = fold_ff - back;
      near = diff[RemW-1:0];
   end

   // Three steps for a general size: fold the key bytes, estimate the
   // quotient, then subtract it out and correct.
   always_comb begin
      fold_vld_in = 1'b0;
      quot_vld_in = fold_vld_ff;
      done_in     = quot_vld_ff;
      fold_in     = fold_ff;
      quot_in     = prod[2*FoldW-1:FoldW];
      rem_in      = rem_ff;
      if (quot_vld_ff) begin
         rem_in = (near >= SizeR) ? SlotW'(near - SizeR) : SlotW'(near);
      end
      if (start) begin
         if (IsPow2) begin
            // A power-of-two size keeps the low key bits.
            rem_in  = key[SlotW-1:0];
            done_in = 1'b1;
         end else begin
            fold_vld_in = 1'b1;
            fold_in     = FoldW'(key[7:0]) +
                          FoldW'(key[15:8]) * Weight1 +
                          FoldW'(key[23:16]) * Weight2 +
                          FoldW'(key[qpht_pkg::KEY_W-1:24]) * Weight3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_vld_ff <= 1'b0;
         quot_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         fold_vld_ff <= fold_vld_in;
         quot_vld_ff <= quot_vld_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

// ===== design/qpht_store.sv =====
`timescale 1ns / 1ps

module qpht_store #(
   parameter int TableSize = qpht_pkg::DEF_TABLE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(TableSize)-1:0] rd_addr,
   output qpht_pkg::entry_type          rd_entry,
   input  logic                         wr_en,
   input  logic [$clog2(TableSize)-1:0] wr_addr,
   input  qpht_pkg::entry_type          wr_entry,
   output logic                         clear_busy
);

   localparam int SlotW = $clog2(TableSize);

   qpht_pkg::entry_type mem [TableSize];
   qpht_pkg::entry_type rd_entry_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [SlotW-1:0] clr_addr_ff, clr_addr_in;
   logic             mem_we;
   logic [SlotW-1:0] mem_wa;
   qpht_pkg::entry_type mem_wd;

   // After reset, sweep the table once to clear every occupied mark.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SlotW'(TableSize - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The clearing sweep owns the write port while it runs.
   always_comb begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_entry;
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end
   end

   // Memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry   = rd_entry_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== design/quadratic_probe_hash_table.sv =====
`timescale 1ns / 1ps

// Open-addressing key table with quadratic probing over TableSize slots. Each
// request carries an operation (insert, delete, search; the unused code acts as
// a search) and a key; the block answers with one response per request. The
// home slot is the key modulo TableSize, and probe i visits home + i*i modulo
// TableSize. After reset the table runs a clearing sweep over every slot
// during which no request is taken. A request is then registered on entry,
// goes through the home-slot computation (the low key bits for a power-of-two
// size, otherwise a byte-folding and reciprocal-multiplication modulo unit),
// reads the probes one after another through the single read port of the
// table memory, whose read is registered, and moves the answer into the
// response register. A request that walks the whole path without a decision
// takes a closing step to settle on a full or not-found answer.
// Requests are handled one at a time; a new request is accepted while the
// previous response still waits in the output register.
module quadratic_probe_hash_table #(
   parameter int TableSize = qpht_pkg::DEF_TABLE_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qpht_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qpht_pkg::rsp_type rsp_payload
);

   localparam int SlotW  = $clog2(TableSize);
   localparam int StepW  = $clog2(TableSize + 1);
   localparam int SumW   = SlotW + 2;
   localparam int OutW   = qpht_pkg::SLOT_W;

   localparam logic [StepW-1:0] LastStep = StepW'(TableSize);
   localparam logic [SumW-1:0]  SizeX1   = SumW'(TableSize);
   localparam logic [SumW-1:0]  SizeX2   = SumW'(2 * TableSize);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HASH  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [qpht_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [qpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [SlotW-1:0]              iss_slot_ff, iss_slot_in;
   logic [StepW-1:0]              iss_step_ff, iss_step_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [SlotW-1:0]              chk_slot_ff, chk_slot_in;
   qpht_pkg::rsp_type             res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   qpht_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          req_fire;
   logic                          home_done;
   logic [SlotW-1:0]              home_slot;
   logic                          clear_busy;
   logic                          issuing;
   logic [SumW-1:0]               next_sum;
   logic [SumW-1:0]               next_a;
   logic [SumW-1:0]               next_b;
   logic                          is_insert;
   logic                          is_delete;
   qpht_pkg::entry_type           rd_entry;
   logic                          mem_wr_en;
   qpht_pkg::entry_type           mem_wr_entry;

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign req_fire  = req_valid && req_ready;

   qpht_home #(
      .TableSize(TableSize)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(req_fire),
      .key  (req_payload.key),
      .done (home_done),
      .home (home_slot)
   );

   qpht_store #(
      .TableSize(TableSize)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (issuing),
      .rd_addr   (iss_slot_ff),
      .rd_entry  (rd_entry),
      .wr_en     (mem_wr_en),
      .wr_addr   (chk_slot_ff),
      .wr_entry  (mem_wr_entry),
      .clear_busy(clear_busy)
   );

   assign is_insert = (mode_ff == qpht_pkg::MODE_INSERT);
   assign is_delete = (mode_ff == qpht_pkg::MODE_DELETE);
   assign issuing   = (state_ff == ST_PROBE) && (iss_step_ff != LastStep);

   // Next probe slot: slot + (2*step + 1) stays below three times the size.
   always_comb begin
      next_sum = SumW'(iss_slot_ff) + SumW'({iss_step_ff, 1'b1});
      next_a   = (next_sum >= SizeX2) ? next_sum - SizeX2 : next_sum;
      next_b   = (next_a >= SizeX1) ? next_a - SizeX1 : next_a;
   end

   // Request sequencer: hash, probe with one read per cycle, then respond.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      iss_slot_in  = iss_slot_ff;
      iss_step_in  = iss_step_ff;
      chk_valid_in = chk_valid_ff;
      chk_slot_in  = chk_slot_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_entry = '{occupied: 1'b1, key: key_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_payload.mode;
               key_in   = req_payload.key;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (home_done) begin
               iss_slot_in  = home_slot;
               iss_step_in  = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // Issue side keeps reading along the probe path.
            iss_slot_in  = SlotW'(next_b);
            iss_step_in  = issuing ? iss_step_ff + 1'b1 : iss_step_ff;
            chk_valid_in = issuing;
            chk_slot_in  = iss_slot_ff;
            if (chk_valid_ff) begin
               if (is_insert) begin
                  if (!rd_entry.occupied) begin
                     mem_wr_en    = 1'b1;
                     res_in       = '{status: qpht_pkg::STATUS_INSERTED,
                                      slot: OutW'(chk_slot_ff)};
                     chk_valid_in = 1'b0;
                     state_in     = ST_DONE;
                  end
               end else if (!rd_entry.occupied) begin
                  res_in       = '{status: qpht_pkg::STATUS_NOT_FOUND, slot: '0};
                  chk_valid_in = 1'b0;
                  state_in     = ST_DONE;
               end else if (rd_entry.key == key_ff) begin
                  if (is_delete) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_entry = '{occupied: 1'b0, key: key_ff};
                     res_in       = '{status: qpht_pkg::STATUS_DELETED,
                                      slot: OutW'(chk_slot_ff)};
                  end else begin
                     res_in = '{status: qpht_pkg::STATUS_FOUND,
                                slot: OutW'(chk_slot_ff)};
                  end
                  chk_valid_in = 1'b0;
                  state_in     = ST_DONE;
               end
            end else if (!issuing) begin
               // Every probe on the path has been checked without a decision.
               res_in   = is_insert ?
                          '{status: qpht_pkg::STATUS_FULL, slot: '0} :
                          '{status: qpht_pkg::STATUS_NOT_FOUND, slot: '0};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register parts the result from the sequencer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      iss_slot_ff <= iss_slot_in;
      iss_step_ff <= iss_step_in;
      chk_slot_ff <= chk_slot_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Table writes only come from a checked probe.
   a_write_from_check: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_PROBE) && chk_valid_ff)
      else $error("table write outside a checked probe");

   // No pending check outside the probe phase.
   a_check_in_probe: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (state_ff == ST_PROBE))
      else $error("pending check outside probe phase");

   // The probe counter never runs past the table size.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (iss_step_ff <= LastStep))
      else $error("probe count exceeded table size");

   // No request is taken during the clearing sweep.
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("request accepted while clearing");

   // Full and not-found responses carry slot zero.
   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == qpht_pkg::STATUS_FULL ||
                       rsp_ff.status == qpht_pkg::STATUS_NOT_FOUND)
      |-> (rsp_ff.slot == '0))
      else $error("miss response with nonzero slot");

endmodule
